// ----- rtl/volt_per_octave_exp_converter_assert.svh -----
// Assertion macros for the volt-per-octave exponential converter.
`ifndef VOLT_PER_OCTAVE_EXP_CONVERTER_ASSERT_SVH
`define VOLT_PER_OCTAVE_EXP_CONVERTER_ASSERT_SVH

`ifndef SYNTH

// Check on every rising edge of clk_i, masked while rst_ni is low.
`define VPO_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Check on every rising edge of clk_i, reset included.
`define VPO_ASSERT_NR(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) prop) \
    else $error(msg);

`else

`define VPO_ASSERT(lbl, prop, msg)

`define VPO_ASSERT_NR(lbl, prop, msg)

`endif

`endif

// ----- rtl/vpo_pkg.sv -----
// Shared widths and exponent table builder for the volt-per-octave converter.
`timescale 1ns / 1ps
`default_nettype none

package vpo_pkg;

  // Field and datapath widths
  localparam int CV_W      = 24;              // signed Q3.20 sample
  localparam int MULT_W    = 31;              // unsigned Q11.20 result
  localparam int FRAC_BITS = 20;
  localparam int TAB_W     = FRAC_BITS + 2;   // table entries, Q2.20 up to 2.0
  localparam int ONE_Q20   = 1 << FRAC_BITS;

  // Integer square root, rounded to nearest (half rounds down)
  function automatic longint unsigned isqrt_round(input longint unsigned x);
    longint unsigned r;
    longint unsigned bit_v;
    longint unsigned rem_v;
    r     = 64'd0;
    bit_v = 64'd1 << 62;
    rem_v = x;
    for (int i = 0; i < 32; i++) begin
      if (rem_v >= r + bit_v) begin
        rem_v = rem_v - (r + bit_v);
        r     = (r >> 1) + bit_v;
      end else begin
        r = r >> 1;
      end
      bit_v = bit_v >> 2;
    end
    if (rem_v > r) begin
      r = r + 64'd1;
    end
    return r;
  endfunction

  // Entry k of the 2^(k / 2^tb) table in Q2.20, built from chained Q.31 roots
  function automatic logic [TAB_W-1:0] exp_entry(input int k, input int tb);
    longint unsigned acc;
    longint unsigned root;
    acc  = 64'd1 << 31;
    root = 64'd0;
    if (k == (1 << tb)) begin
      return TAB_W'(2 * ONE_Q20);
    end
    for (int j = 1; j <= tb; j++) begin
      if (j == 1) begin
        root = isqrt_round(64'd1 << 63);
      end else begin
        root = isqrt_round(root << 31);
      end
      if (((k >> (tb - j)) & 1) != 0) begin
        acc = (acc * root + (64'd1 << 30)) >> 31;
      end
    end
    return TAB_W'((acc + (64'd1 << 10)) >> 11);
  endfunction

endpackage

`default_nettype wire

// ----- rtl/vpo_scale.sv -----
// Stage one: clamp the sample, scale by full-scale volts, split exponent and fraction.
`timescale 1ns / 1ps
`default_nettype none

`include "volt_per_octave_exp_converter_assert.svh"

module vpo_scale #(
  parameter int FULL_SCALE_VOLTS = 10,
  parameter int E_W              = 5
) (
  input  wire logic                                clk_i,
  input  wire logic                                rst_ni,
  input  wire logic                                valid_i,
  output logic                                     stall_o,
  input  wire logic signed [vpo_pkg::CV_W-1:0]     cv_sample_i,
  output logic                                     valid_o,
  input  wire logic                                stall_i,
  output logic             [E_W-1:0]               exp_o,
  output logic             [vpo_pkg::FRAC_BITS-1:0] frac_o
);

  localparam int FB  = vpo_pkg::FRAC_BITS;
  localparam int CB_W = FB + 2;
  localparam int U_W  = FB + E_W;
  localparam logic signed [vpo_pkg::CV_W-1:0] ONE_S = vpo_pkg::CV_W'(vpo_pkg::ONE_Q20);

  logic signed [vpo_pkg::CV_W-1:0] cv_off;
  logic        [CB_W-1:0]          cv_biased;
  logic        [U_W-1:0]           scaled;
  logic                            valid_q;
  logic        [E_W-1:0]           exp_q;
  logic        [FB-1:0]            frac_q;

  // Clamp to plus or minus one and shift to an unsigned range [0, 2.0]
  assign cv_off = cv_sample_i + ONE_S;

  always_comb begin
    if (cv_sample_i > ONE_S) begin
      cv_biased = CB_W'(2 * vpo_pkg::ONE_Q20);
    end else if (cv_sample_i < -ONE_S) begin
      cv_biased = '0;
    end else begin
      cv_biased = cv_off[CB_W-1:0];
    end
  end

  // Biased exponent sits above the 20 fraction bits
  assign scaled = U_W'(cv_biased) * U_W'(FULL_SCALE_VOLTS);

  assign stall_o = valid_q && stall_i;

  // Advance the stage whenever the next one takes a beat or this one is empty
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      exp_q  <= scaled[U_W-1:FB];
      frac_q <= scaled[FB-1:0];
    end
  end

  assign valid_o = valid_q;
  assign exp_o   = exp_q;
  assign frac_o  = frac_q;

  `VPO_ASSERT(a_exp_in_range, valid_q |-> (exp_q < E_W'(2 * FULL_SCALE_VOLTS) || (exp_q == E_W'(2 * FULL_SCALE_VOLTS) && frac_q == '0)), "biased exponent beyond full scale")

endmodule

`default_nettype wire

// ----- rtl/vpo_interp.sv -----
// Stages two and three: exponent table lookup and linear interpolation step.
`timescale 1ns / 1ps
`default_nettype none

`include "volt_per_octave_exp_converter_assert.svh"

module vpo_interp #(
  parameter int TABLE_BITS = 6,
  parameter int E_W        = 5
) (
  input  wire logic                                 clk_i,
  input  wire logic                                 rst_ni,
  input  wire logic                                 valid_i,
  output logic                                      stall_o,
  input  wire logic [E_W-1:0]                       exp_i,
  input  wire logic [vpo_pkg::FRAC_BITS-1:0]        frac_i,
  output logic                                      valid_o,
  input  wire logic                                 stall_i,
  output logic [E_W-1:0]                            exp_o,
  output logic [vpo_pkg::TAB_W-1:0]                 lo_o,
  output logic [vpo_pkg::TAB_W-1:0]                 step_o
);

  localparam int FB    = vpo_pkg::FRAC_BITS;
  localparam int TW    = vpo_pkg::TAB_W;
  localparam int LOW_W = FB - TABLE_BITS;
  localparam int TAB_N = (1 << TABLE_BITS) + 1;
  localparam int IX_W  = TABLE_BITS + 1;
  localparam int P_W   = TW + LOW_W;

  logic [TW-1:0]         tab [TAB_N];
  logic [IX_W-1:0]       idx_lo;
  logic [IX_W-1:0]       idx_hi;
  logic [TW-1:0]         lo_val;
  logic [TW-1:0]         hi_val;
  logic [P_W-1:0]        prod;
  logic                  stall2;
  logic                  stall3;

  logic                  s2_valid_q;
  logic [E_W-1:0]        s2_exp_q;
  logic [TW-1:0]         s2_lo_q;
  logic [TW-1:0]         s2_diff_q;
  logic [LOW_W-1:0]      s2_rem_q;

  logic                  s3_valid_q;
  logic [E_W-1:0]        s3_exp_q;
  logic [TW-1:0]         s3_lo_q;
  logic [TW-1:0]         s3_step_q;

  // Constant exponent table, one entry past the end for the upper neighbour
  for (genvar k = 0; k < TAB_N; k++) begin : g_tab
    assign tab[k] = vpo_pkg::exp_entry(k, TABLE_BITS);
  end

  // Look up both neighbours of the fraction's top bits
  assign idx_lo = {1'b0, frac_i[FB-1:LOW_W]};
  assign idx_hi = idx_lo + IX_W'(1);
  assign lo_val = tab[idx_lo];
  assign hi_val = tab[idx_hi];

  assign stall3  = s3_valid_q && stall_i;
  assign stall2  = s2_valid_q && stall3;
  assign stall_o = stall2;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      s2_valid_q <= 1'b0;
      s3_valid_q <= 1'b0;
    end else begin
      if (!stall2) begin
        s2_valid_q <= valid_i;
      end
      if (!stall3) begin
        s3_valid_q <= s2_valid_q;
      end
    end
  end

  // Hold the lookup result and the neighbour difference
  always_ff @(posedge clk_i) begin
    if (!stall2 && valid_i) begin
      s2_exp_q  <= exp_i;
      s2_lo_q   <= lo_val;
      s2_diff_q <= hi_val - lo_val;
      s2_rem_q  <= frac_i[LOW_W-1:0];
    end
  end

  // Scale the difference by the low fraction bits, truncating
  assign prod = P_W'(s2_diff_q) * P_W'(s2_rem_q);

  always_ff @(posedge clk_i) begin
    if (!stall3 && s2_valid_q) begin
      s3_exp_q  <= s2_exp_q;
      s3_lo_q   <= s2_lo_q;
      s3_step_q <= prod[P_W-1:LOW_W];
    end
  end

  assign valid_o = s3_valid_q;
  assign exp_o   = s3_exp_q;
  assign lo_o    = s3_lo_q;
  assign step_o  = s3_step_q;

  `VPO_ASSERT(a_entry_bounds, s2_valid_q |-> (s2_lo_q >= TW'(vpo_pkg::ONE_Q20) && ({1'b0, s2_lo_q} + {1'b0, s2_diff_q}) <= (TW + 1)'(2 * vpo_pkg::ONE_Q20)), "table neighbours outside [1.0, 2.0]")

endmodule

`default_nettype wire

// ----- rtl/vpo_shift.sv -----
// Stage four: finish the interpolation and apply the octave shift.
`timescale 1ns / 1ps
`default_nettype none

module vpo_shift #(
  parameter int FULL_SCALE_VOLTS = 10,
  parameter int E_W              = 5
) (
  input  wire logic                          clk_i,
  input  wire logic                          rst_ni,
  input  wire logic                          valid_i,
  output logic                               stall_o,
  input  wire logic [E_W-1:0]                exp_i,
  input  wire logic [vpo_pkg::TAB_W-1:0]     lo_i,
  input  wire logic [vpo_pkg::TAB_W-1:0]     step_i,
  output logic                               valid_o,
  input  wire logic                          stall_i,
  output logic [vpo_pkg::MULT_W-1:0]         multiplier_o
);

  localparam int TW   = vpo_pkg::TAB_W;
  localparam int MW   = vpo_pkg::MULT_W;
  localparam int SH_W = MW + TW;
  localparam logic [E_W-1:0] BIAS = E_W'(FULL_SCALE_VOLTS);

  logic [TW-1:0]   interp;
  logic [SH_W-1:0] wide;
  logic [SH_W-1:0] shifted;
  logic            valid_q;
  logic [MW-1:0]   mult_q;

  // Interpolated mantissa in Q2.20
  assign interp = lo_i + step_i;
  assign wide   = SH_W'(interp);

  // Shift left for positive octaves, right with truncation for negative ones
  always_comb begin
    if (exp_i >= BIAS) begin
      shifted = wide << (exp_i - BIAS);
    end else begin
      shifted = wide >> (BIAS - exp_i);
    end
  end

  assign stall_o = valid_q && stall_i;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= 1'b0;
    end else if (!stall_o) begin
      valid_q <= valid_i;
    end
  end

  always_ff @(posedge clk_i) begin
    if (!stall_o && valid_i) begin
      mult_q <= shifted[MW-1:0];
    end
  end

  assign valid_o      = valid_q;
  assign multiplier_o = mult_q;

endmodule

`default_nettype wire

// ----- rtl/volt_per_octave_exp_converter.sv -----
// Top level of the volt-per-octave exponential converter pipeline.
// Usage:
//   Input channel: in_valid_i / in_stall_o carry cv_sample_i, a signed Q3.20
//   control voltage; anything beyond plus or minus 1.0 is clamped.
//   Output channel: out_valid_o / out_stall_i carry multiplier_o, unsigned
//   Q11.20, equal to 2^(clamped sample * FULL_SCALE_VOLTS).
//   A beat moves on a rising edge where valid is high and stall is low.
//   Pipeline: 4 register stages (clamp and scale, table lookup, interpolation
//   multiply, octave shift); out_valid_o rises once the input beat has passed
//   all four, and the result beat is taken when out_stall_i is low.
//   Throughput: one beat per cycle while out_stall_i is low; each stage loads
//   when the next takes its beat or is empty, so bubbles are squeezed out.
//   The exponent table has 2^TABLE_BITS + 1 constant entries; lower and
//   upper neighbour are read in the same cycle.
//   Reset (rst_ni low, asynchronous) empties every stage; no clearing pass.
//   When the receiver stalls, the last result holds; upstream stages keep
//   filling, and in_stall_o rises only once all four stages hold a beat.
`timescale 1ns / 1ps
`default_nettype none

`include "volt_per_octave_exp_converter_assert.svh"

module volt_per_octave_exp_converter #(
  parameter int FULL_SCALE_VOLTS = 10,
  parameter int TABLE_BITS       = 6
) (
  input  wire logic                            clk_i,
  input  wire logic                            rst_ni,
  input  wire logic                            in_valid_i,
  output logic                                 in_stall_o,
  input  wire logic signed [vpo_pkg::CV_W-1:0] cv_sample_i,
  output logic                                 out_valid_o,
  input  wire logic                            out_stall_i,
  output logic [vpo_pkg::MULT_W-1:0]           multiplier_o
);

  localparam int E_W = $clog2(2 * FULL_SCALE_VOLTS + 1);

  logic                               s1_valid;
  logic                               s1_stall;
  logic [E_W-1:0]                     s1_exp;
  logic [vpo_pkg::FRAC_BITS-1:0]      s1_frac;
  logic                               s3_valid;
  logic                               s3_stall;
  logic [E_W-1:0]                     s3_exp;
  logic [vpo_pkg::TAB_W-1:0]          s3_lo;
  logic [vpo_pkg::TAB_W-1:0]          s3_step;

  // Clamp, scale and split
  vpo_scale #(
    .FULL_SCALE_VOLTS(FULL_SCALE_VOLTS),
    .E_W             (E_W)
  ) u_scale (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .valid_i    (in_valid_i),
    .stall_o    (in_stall_o),
    .cv_sample_i(cv_sample_i),
    .valid_o    (s1_valid),
    .stall_i    (s1_stall),
    .exp_o      (s1_exp),
    .frac_o     (s1_frac)
  );

  // Table lookup and interpolation step
  vpo_interp #(
    .TABLE_BITS(TABLE_BITS),
    .E_W       (E_W)
  ) u_interp (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .valid_i(s1_valid),
    .stall_o(s1_stall),
    .exp_i  (s1_exp),
    .frac_i (s1_frac),
    .valid_o(s3_valid),
    .stall_i(s3_stall),
    .exp_o  (s3_exp),
    .lo_o   (s3_lo),
    .step_o (s3_step)
  );

  // Octave shift and output register
  vpo_shift #(
    .FULL_SCALE_VOLTS(FULL_SCALE_VOLTS),
    .E_W             (E_W)
  ) u_shift (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .valid_i     (s3_valid),
    .stall_o     (s3_stall),
    .exp_i       (s3_exp),
    .lo_i        (s3_lo),
    .step_i      (s3_step),
    .valid_o     (out_valid_o),
    .stall_i     (out_stall_i),
    .multiplier_o(multiplier_o)
  );

  `VPO_ASSERT_NR(a_free_out_no_stall, !out_stall_i |-> !in_stall_o,
                 "input stalled while output is free")
  `VPO_ASSERT(a_stall_needs_result, in_stall_o |-> out_valid_o,
              "input stalled with no result waiting")

endmodule

`default_nettype wire
